// File: rtl/core/gsm_pkg.sv
// ----------------------------------------------------------------------------
// gsm_pkg: shared types and constants for the gated SiLU multiply block
// Fixed point formats, widths of the internal datapath, the 2^-x table and
// the sideband record that travels along the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gsm_pkg;

    // Operand format, Q4.12
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;
    localparam int MAG_W      = DATA_WIDTH + 1;   // magnitude incl. 2^(W-1)

    // exp(-a) = 2^-(a*log2e), log2e in Q16
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam int TFULL_W = MAG_W + 17;
    localparam int T16_W   = TFULL_W - FRAC_BITS;
    localparam int N_W     = T16_W - 16;
    localparam int Q16_W   = 17;                  // holds 0..65536
    localparam logic [Q16_W-1:0] ONE_Q16 = 17'd65536;
    localparam int SHIFT_LIMIT = 17;

    // Reciprocal: floor(2^32 / (65536 + e)), quotient 17 bits
    localparam int DEN_W         = Q16_W + 1;
    localparam int REM_W         = Q16_W;
    localparam int DIV_STEPS     = Q16_W;
    localparam int DIV_PER_STAGE = 3;
    localparam int DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
    localparam logic [REM_W-1:0] REM_INIT = 17'd32768;

    // Product widths
    localparam int HPROD_W = MAG_W + Q16_W;
    localparam int H_W     = HPROD_W - 16;
    localparam int MPROD_W = MAG_W + H_W;
    localparam int M_W     = MPROD_W - FRAC_BITS;

    // Sideband carried beside the sigmoid datapath
    typedef struct packed {
        logic [MAG_W-1:0] x_mag;
        logic             x_neg;
        logic [MAG_W-1:0] g_mag;
        logic             g_neg;
    } side_t;

    // 2^(-j/16) in Q16, j = 0..16
    function automatic logic [Q16_W-1:0] pow2_neg(input logic [4:0] idx);
        logic [Q16_W-1:0] val;
        case (idx)
            5'd0:    val = 17'd65536;
            5'd1:    val = 17'd62757;
            5'd2:    val = 17'd60097;
            5'd3:    val = 17'd57549;
            5'd4:    val = 17'd55109;
            5'd5:    val = 17'd52773;
            5'd6:    val = 17'd50535;
            5'd7:    val = 17'd48393;
            5'd8:    val = 17'd46341;
            5'd9:    val = 17'd44376;
            5'd10:   val = 17'd42495;
            5'd11:   val = 17'd40693;
            5'd12:   val = 17'd38968;
            5'd13:   val = 17'd37316;
            5'd14:   val = 17'd35734;
            5'd15:   val = 17'd34219;
            5'd16:   val = 17'd32768;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/gsm_in_if.sv
// ----------------------------------------------------------------------------
// gsm_in_if: request channel carrying one x / gate element pair
// Valid/ready handshake; a request moves when both are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_value;
    logic signed [15:0] gate_value;

    modport source (output valid, output x_value, output gate_value, input ready);
    modport sink   (input valid, input x_value, input gate_value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/gsm_out_if.sv
// ----------------------------------------------------------------------------
// gsm_out_if: result channel carrying one saturated product
// Valid/ready handshake; a result moves when both are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] y_value;
    logic               saturated;

    modport source (output valid, output y_value, output saturated, input ready);
    modport sink   (input valid, input y_value, input saturated, output ready);
endinterface

`default_nettype wire

// File: rtl/core/gated_silu_multiply_top.sv
// ----------------------------------------------------------------------------
// gated_silu_multiply_top: y = x * g * sigmoid(g), Q4.12, saturated
// Pipeline of 4 exp stages, 6 divider stages and 3 product stages.
// Throughput one request per cycle unless the output stalls; every stage
// has its own valid bit and fills bubbles, so input is taken while a result
// waits at the output. Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gated_silu_multiply_top (
    input  logic       clk,
    input  logic       rst_n,
    gsm_in_if.sink     req,
    gsm_out_if.source  rsp
);
    import gsm_pkg::*;

    logic             fe_valid, fe_ready;
    side_t            fe_side;
    logic [Q16_W-1:0] fe_e;
    logic             dv_valid, dv_ready;
    side_t            dv_side;
    logic [Q16_W-1:0] dv_sp;

    // exp(-|g|)
    gsm_exp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_x      (req.x_value),
        .in_g      (req.gate_value),
        .out_valid (fe_valid),
        .out_ready (fe_ready),
        .out_side  (fe_side),
        .out_e     (fe_e)
    );

    // sigmoid(|g|) by reciprocal
    gsm_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_side   (fe_side),
        .in_e      (fe_e),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_side  (dv_side),
        .out_sp    (dv_sp)
    );

    // products, rounding, saturation
    gsm_product u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_side   (dv_side),
        .in_sp     (dv_sp),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_y     (rsp.y_value),
        .out_sat   (rsp.saturated)
    );

endmodule

`default_nettype wire

// File: rtl/core/gsm_exp_front.sv
// ----------------------------------------------------------------------------
// gsm_exp_front: sign/magnitude split and exp(-|g|) approximation
// Four stages: split, scale by log2e, table lookup + slope product,
// interpolate and shift.
// ----------------------------------------------------------------------------
`default_nettype none

module gsm_exp_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [gsm_pkg::DATA_WIDTH-1:0] in_x,
    input  logic signed [gsm_pkg::DATA_WIDTH-1:0] in_g,
    output logic                              out_valid,
    input  logic                              out_ready,
    output gsm_pkg::side_t                    out_side,
    output logic [gsm_pkg::Q16_W-1:0]         out_e
);
    import gsm_pkg::*;

    localparam int NST = 4;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] en;

    side_t                  side0_reg, side1_reg, side2_reg, side3_reg;
    logic [TFULL_W-1:0]     tfull_reg;
    logic [Q16_W-1:0]       hi_reg;
    logic [N_W-1:0]         n_reg;
    logic [Q16_W+11:0]      slope_reg;
    logic [Q16_W-1:0]       e_reg;

    side_t                  side0_next;
    logic [T16_W-1:0]       t16;
    logic [3:0]             seg;
    logic [11:0]            frac;
    logic [Q16_W-1:0]       hi_val, lo_val;
    logic [Q16_W-1:0]       p_val;
    logic [Q16_W-1:0]       e_next;

    // Stall chain: a stage loads when empty or when its successor moves
    assign en[NST-1] = !valid_reg[NST-1] || out_ready;
    assign en[2]     = !valid_reg[2] || en[3];
    assign en[1]     = !valid_reg[1] || en[2];
    assign en[0]     = !valid_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = valid_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0]) valid_reg[0] <= in_valid;
            if (en[1]) valid_reg[1] <= valid_reg[0];
            if (en[2]) valid_reg[2] <= valid_reg[1];
            if (en[3]) valid_reg[3] <= valid_reg[2];
        end
    end

    // Split into sign and magnitude; the most negative value keeps 2^(W-1)
    always_comb
    begin
        side0_next.x_neg = in_x[DATA_WIDTH-1];
        side0_next.g_neg = in_g[DATA_WIDTH-1];
        side0_next.x_mag = in_x[DATA_WIDTH-1] ? (MAG_W'(0) - {in_x[DATA_WIDTH-1], in_x})
                                              : {1'b0, in_x};
        side0_next.g_mag = in_g[DATA_WIDTH-1] ? (MAG_W'(0) - {in_g[DATA_WIDTH-1], in_g})
                                              : {1'b0, in_g};
    end

    // Segment lookup and interpolation terms
    always_comb
    begin
        t16    = tfull_reg[TFULL_W-1:FRAC_BITS];
        seg    = t16[15:12];
        frac   = t16[11:0];
        hi_val = pow2_neg({1'b0, seg});
        lo_val = pow2_neg({1'b0, seg} + 5'd1);
    end

    // Interpolate and shift by the integer part
    always_comb
    begin
        p_val  = hi_reg - slope_reg[Q16_W+11:12];
        e_next = (n_reg >= N_W'(SHIFT_LIMIT)) ? '0 : (p_val >> n_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side0_reg <= side0_next;
        end
        if (en[1])
        begin
            side1_reg <= side0_reg;
            tfull_reg <= side0_reg.g_mag * LOG2E_Q16;
        end
        if (en[2])
        begin
            side2_reg <= side1_reg;
            hi_reg    <= hi_val;
            n_reg     <= t16[T16_W-1:16];
            slope_reg <= (hi_val - lo_val) * frac;
        end
        if (en[3])
        begin
            side3_reg <= side2_reg;
            e_reg     <= e_next;
        end
    end

    assign out_side = side3_reg;
    assign out_e    = e_reg;

endmodule

`default_nettype wire

// File: rtl/core/gsm_recip.sv
// ----------------------------------------------------------------------------
// gsm_recip: pipelined restoring divider for sigmoid(|g|) = 2^32/(2^16+e)
// One quotient bit per step, DIV_PER_STAGE steps per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gsm_recip (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  gsm_pkg::side_t            in_side,
    input  logic [gsm_pkg::Q16_W-1:0] in_e,
    output logic                      out_valid,
    input  logic                      out_ready,
    output gsm_pkg::side_t            out_side,
    output logic [gsm_pkg::Q16_W-1:0] out_sp
);
    import gsm_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES-1:0] en;

    logic [REM_W-1:0]  rem_reg  [DIV_STAGES];
    logic [Q16_W-1:0]  q_reg    [DIV_STAGES];
    logic [DEN_W-1:0]  den_reg  [DIV_STAGES];
    side_t             side_reg [DIV_STAGES];

    logic [REM_W-1:0]  rem_next [DIV_STAGES];
    logic [Q16_W-1:0]  q_next   [DIV_STAGES];
    logic [DEN_W-1:0]  den_next [DIV_STAGES];
    side_t             side_next[DIV_STAGES];

    assign in_ready  = en[0];
    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];
    assign out_sp    = q_reg[DIV_STAGES-1];

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++)
        begin : g_stage
            // Stall chain
            if (s == DIV_STAGES - 1)
            begin : g_last
                assign en[s] = !valid_reg[s] || out_ready;
            end
            else
            begin : g_mid
                assign en[s] = !valid_reg[s] || en[s+1];
            end

            // Stage inputs: first stage builds the divisor
            if (s == 0)
            begin : g_first
                always_comb
                begin : div_steps
                    logic [REM_W-1:0] rem_v;
                    logic [Q16_W-1:0] q_v;
                    logic [DEN_W-1:0] shl;
                    logic [DEN_W-1:0] den_v;
                    den_v = {1'b0, ONE_Q16} + {1'b0, in_e};
                    rem_v = REM_INIT;
                    q_v   = '0;
                    for (int j = 0; j < DIV_PER_STAGE; j++)
                    begin
                        if (j < DIV_STEPS)
                        begin
                            shl = {rem_v, 1'b0};
                            if (shl >= den_v)
                            begin
                                shl = shl - den_v;
                                q_v = {q_v[Q16_W-2:0], 1'b1};
                            end
                            else
                            begin
                                q_v = {q_v[Q16_W-2:0], 1'b0};
                            end
                            rem_v = shl[REM_W-1:0];
                        end
                    end
                    rem_next[s]  = rem_v;
                    q_next[s]    = q_v;
                    den_next[s]  = den_v;
                    side_next[s] = in_side;
                end
            end
            else
            begin : g_rest
                always_comb
                begin : div_steps
                    logic [REM_W-1:0] rem_v;
                    logic [Q16_W-1:0] q_v;
                    logic [DEN_W-1:0] shl;
                    rem_v = rem_reg[s-1];
                    q_v   = q_reg[s-1];
                    for (int j = 0; j < DIV_PER_STAGE; j++)
                    begin
                        if (s * DIV_PER_STAGE + j < DIV_STEPS)
                        begin
                            shl = {rem_v, 1'b0};
                            if (shl >= den_reg[s-1])
                            begin
                                shl = shl - den_reg[s-1];
                                q_v = {q_v[Q16_W-2:0], 1'b1};
                            end
                            else
                            begin
                                q_v = {q_v[Q16_W-2:0], 1'b0};
                            end
                            rem_v = shl[REM_W-1:0];
                        end
                    end
                    rem_next[s]  = rem_v;
                    q_next[s]    = q_v;
                    den_next[s]  = den_reg[s-1];
                    side_next[s] = side_reg[s-1];
                end
            end

            // Stage registers
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (en[s])
                begin
                    valid_reg[s] <= (s == 0) ? in_valid : valid_reg[(s == 0) ? 0 : s-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    rem_reg[s]  <= rem_next[s];
                    q_reg[s]    <= q_next[s];
                    den_reg[s]  <= den_next[s];
                    side_reg[s] <= side_next[s];
                end
            end
        end
    endgenerate

endmodule

`default_nettype wire

// File: rtl/core/gsm_product.sv
// ----------------------------------------------------------------------------
// gsm_product: g*sigmoid(g), times x, rounding and saturation
// Three stages; the last one is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gsm_product (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  gsm_pkg::side_t                    in_side,
    input  logic [gsm_pkg::Q16_W-1:0]         in_sp,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [gsm_pkg::DATA_WIDTH-1:0] out_y,
    output logic                              out_sat
);
    import gsm_pkg::*;

    localparam int NST = 3;
    localparam logic [M_W-1:0] POS_MAX = M_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam logic [M_W-1:0] NEG_MAX = M_W'(64'd1 << (DATA_WIDTH - 1));

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] en;

    logic [HPROD_W-1:0]    hprod_reg;
    logic [MAG_W-1:0]      xmag0_reg;
    logic                  yneg0_reg;
    logic [MPROD_W-1:0]    mprod_reg;
    logic                  yneg1_reg;
    logic [DATA_WIDTH-1:0] y_reg;
    logic                  sat_reg;

    logic [Q16_W-1:0]      s_val;
    logic [HPROD_W:0]      h_round;
    logic [H_W-1:0]        h_val;
    logic [MPROD_W:0]      m_round;
    logic [M_W-1:0]        m_val;
    logic                  y_neg;
    logic [M_W-1:0]        m_clamp;
    logic [DATA_WIDTH-1:0] y_next;
    logic                  sat_next;

    assign en[2]     = !valid_reg[2] || out_ready;
    assign en[1]     = !valid_reg[1] || en[2];
    assign en[0]     = !valid_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = valid_reg[2];
    assign out_y     = y_reg;
    assign out_sat   = sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0]) valid_reg[0] <= in_valid;
            if (en[1]) valid_reg[1] <= valid_reg[0];
            if (en[2]) valid_reg[2] <= valid_reg[1];
        end
    end

    // Sigmoid of a negative gate is one minus sigmoid of its magnitude
    assign s_val = in_side.g_neg ? (ONE_Q16 - in_sp) : in_sp;

    // h = |g * sigmoid(g)|, rounded half up
    always_comb
    begin
        h_round = {1'b0, hprod_reg} + (HPROD_W+1)'(32768);
        h_val   = h_round[HPROD_W-1:16];
    end

    // m = |y| rounded, then sign and clamp
    always_comb
    begin
        m_round = {1'b0, mprod_reg} + (MPROD_W+1)'(1 << (FRAC_BITS - 1));
        m_val   = m_round[MPROD_W-1:FRAC_BITS];
        y_neg   = yneg1_reg && (m_val != '0);
        sat_next = 1'b0;
        m_clamp  = m_val;
        if (y_neg)
        begin
            if (m_val > NEG_MAX)
            begin
                m_clamp  = NEG_MAX;
                sat_next = 1'b1;
            end
            y_next = DATA_WIDTH'(M_W'(0) - m_clamp);
        end
        else
        begin
            if (m_val > POS_MAX)
            begin
                m_clamp  = POS_MAX;
                sat_next = 1'b1;
            end
            y_next = m_clamp[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            hprod_reg <= in_side.g_mag * s_val;
            xmag0_reg <= in_side.x_mag;
            yneg0_reg <= in_side.x_neg ^ in_side.g_neg;
        end
        if (en[1])
        begin
            mprod_reg <= xmag0_reg * h_val;
            yneg1_reg <= yneg0_reg;
        end
        if (en[2])
        begin
            y_reg   <= y_next;
            sat_reg <= sat_next;
        end
    end

endmodule

`default_nettype wire
